// ----- hdl/btp_pkg.sv -----
// Shared types and constants for the branch target predictor.
// Depends on nothing; imported by the predictor top level and its port checker.
package btp_pkg;

	localparam int ADDR_W = 32;   // pc and target width
	localparam int CNT_W  = 2;    // direction counter width
	localparam int HIT_W  = 6;    // width of the entry index ports
	localparam int DRAW_W = 2;    // random draw width

	// request operation codes
	typedef enum logic [1:0] {
		OP_PREDICT    = 2'd0,
		OP_ADD        = 2'd1,
		OP_UPDATE     = 2'd2,
		OP_MISPREDICT = 2'd3
	} op_t;

endpackage

// ----- hdl/branch_target_predictor_unit.sv -----
// Direct-mapped branch target buffer with saturating direction counters.
// Depends on btp_pkg.
//
// Takes one request per cycle while in_ready is high (predict, add entry, update
// entry, count a mispredict) and returns one result per request; a stalled result
// or the clearing pass holds in_ready low. The memories are read into the read
// stage registers, then the request is resolved into the output register. A write
// from the request in the resolve stage is forwarded to the request that is read
// in the same cycle. After reset, in_ready stays low while a clearing pass zeroes
// the tag and counter memories, one entry per cycle, through all TABLE_ENTRIES.
module branch_target_predictor_unit import btp_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNTER_LIMIT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [ADDR_W-1:0] pc,
	input  logic [ADDR_W-1:0] next_pc,
	input  logic              taken,
	input  logic [ADDR_W-1:0] target_pc,
	input  logic [HIT_W-1:0]  entry_index,
	input  logic [DRAW_W-1:0] random_draw,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              predict_taken,
	output logic [ADDR_W-1:0] predicted_pc,
	output logic [HIT_W-1:0]  hit_index,
	output logic [ADDR_W-1:0] branch_total,
	output logic [ADDR_W-1:0] mispredict_total
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNTER_LIMIT - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// entry memories
	logic [ADDR_W-1:0] tag_mem    [TABLE_ENTRIES];
	logic [ADDR_W-1:0] target_mem [TABLE_ENTRIES];
	logic [CNT_W-1:0]  cnt_mem    [TABLE_ENTRIES];

	// clearing pass
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_addr_q;

	// read stage
	logic              valid_s1;
	op_t               op_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic [ADDR_W-1:0] npc_s1;
	logic              taken_s1;
	logic [ADDR_W-1:0] tgt_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic [DRAW_W-1:0] draw_s1;
	logic [ADDR_W-1:0] rd_tag_s1;
	logic [ADDR_W-1:0] rd_tgt_s1;
	logic [CNT_W-1:0]  rd_cnt_s1;
	logic              fwd_tag_s1;
	logic              fwd_tgt_s1;
	logic              fwd_cnt_s1;
	logic [ADDR_W-1:0] fwd_tag_val_s1;
	logic [ADDR_W-1:0] fwd_tgt_val_s1;
	logic [CNT_W-1:0]  fwd_cnt_val_s1;

	logic [ADDR_W-1:0] branch_q;
	logic [ADDR_W-1:0] mispredict_q;

	// request decode
	op_t                    in_op;
	logic [IDX_W-1:0]       pc_slot;
	logic [IDX_W+HIT_W-1:0] ent_wide;
	logic [IDX_W-1:0]       rd_addr;
	logic                   accept;
	logic                   adv_s1;

	assign in_op    = op_t'(operation);
	assign pc_slot  = pc[IDX_W+1:2];
	assign ent_wide = {{IDX_W{1'b0}}, entry_index};
	assign rd_addr  = (in_op == OP_UPDATE) ? ent_wide[IDX_W-1:0] : pc_slot;

	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign accept   = in_valid && in_ready;

	// resolve stage: effective entry contents and the result
	logic [ADDR_W-1:0]      tag_eff;
	logic [ADDR_W-1:0]      tgt_eff;
	logic [CNT_W-1:0]       cnt_eff;
	logic                   hit;
	logic                   p_taken;
	logic [ADDR_W-1:0]      p_pc;
	logic [IDX_W+HIT_W-1:0] addr_wide;
	logic [HIT_W-1:0]       p_idx;
	logic [ADDR_W-1:0]      branch_nxt;
	logic [ADDR_W-1:0]      mispredict_nxt;

	assign tag_eff   = fwd_tag_s1 ? fwd_tag_val_s1 : rd_tag_s1;
	assign tgt_eff   = fwd_tgt_s1 ? fwd_tgt_val_s1 : rd_tgt_s1;
	assign cnt_eff   = fwd_cnt_s1 ? fwd_cnt_val_s1 : rd_cnt_s1;
	assign hit       = (tag_eff == {pc_s1[ADDR_W-1:1], 1'b1});
	assign p_taken   = (op_s1 == OP_PREDICT) && hit && (draw_s1 >= cnt_eff)
		&& (cnt_eff < CNT_TOP);
	assign addr_wide = {{HIT_W{1'b0}}, addr_s1};
	assign p_idx     = p_taken ? addr_wide[HIT_W-1:0] : '0;

	always_comb begin
		if (op_s1 != OP_PREDICT) begin
			p_pc = '0;
		end else if (p_taken) begin
			p_pc = tgt_eff;
		end else begin
			p_pc = npc_s1 + ADDR_W'(4);
		end
	end

	assign branch_nxt     = branch_q + ADDR_W'(op_s1 == OP_PREDICT);
	assign mispredict_nxt = mispredict_q + ADDR_W'(op_s1 == OP_MISPREDICT);

	// write back from the resolve stage
	logic              wr_tag_en;
	logic              wr_tgt_en;
	logic              wr_cnt_en;
	logic [ADDR_W-1:0] tag_new;
	logic [CNT_W-1:0]  cnt_new;

	assign wr_tag_en = adv_s1 && (op_s1 == OP_ADD);
	assign wr_tgt_en = adv_s1 && ((op_s1 == OP_ADD) || ((op_s1 == OP_UPDATE) && taken_s1));
	assign wr_cnt_en = adv_s1 && ((op_s1 == OP_ADD) || (op_s1 == OP_UPDATE));
	assign tag_new   = {pc_s1[ADDR_W-1:1], 1'b1};

	always_comb begin
		cnt_new = cnt_eff;
		if (op_s1 == OP_ADD) begin
			cnt_new = taken_s1 ? '0 : CNT_TOP;
		end else if (taken_s1) begin
			if (cnt_eff != '0) cnt_new = cnt_eff - CNT_W'(1);
		end else begin
			if (cnt_eff < CNT_TOP) cnt_new = cnt_eff + CNT_W'(1);
		end
	end

	// memories: clearing writes, write back, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			tag_mem[clr_addr_q] <= '0;
			cnt_mem[clr_addr_q] <= '0;
		end else begin
			if (wr_tag_en) tag_mem[addr_s1]    <= tag_new;
			if (wr_tgt_en) target_mem[addr_s1] <= tgt_s1;
			if (wr_cnt_en) cnt_mem[addr_s1]    <= cnt_new;
		end
		if (accept) begin
			rd_tag_s1 <= tag_mem[rd_addr];
			rd_tgt_s1 <= target_mem[rd_addr];
			rd_cnt_s1 <= cnt_mem[rd_addr];
		end
	end

	// request payload into the read stage, with forwarding of the write back
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1          <= in_op;
			pc_s1          <= pc;
			npc_s1         <= next_pc;
			taken_s1       <= taken;
			tgt_s1         <= target_pc;
			addr_s1        <= rd_addr;
			draw_s1        <= random_draw;
			fwd_tag_s1     <= wr_tag_en && (addr_s1 == rd_addr);
			fwd_tgt_s1     <= wr_tgt_en && (addr_s1 == rd_addr);
			fwd_cnt_s1     <= wr_cnt_en && (addr_s1 == rd_addr);
			fwd_tag_val_s1 <= tag_new;
			fwd_tgt_val_s1 <= tgt_s1;
			fwd_cnt_val_s1 <= cnt_new;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			predict_taken    <= p_taken;
			predicted_pc     <= p_pc;
			hit_index        <= p_idx;
			branch_total     <= branch_nxt;
			mispredict_total <= mispredict_nxt;
		end
	end

	// control: clearing pass, stage valids, running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			out_valid    <= 1'b0;
			branch_q     <= '0;
			mispredict_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
				if (clr_addr_q == LAST_IDX) clr_busy_q <= 1'b0;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid    <= 1'b1;
				branch_q     <= branch_nxt;
				mispredict_q <= mispredict_nxt;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/btp_checker.sv -----
// Port-level checks for branch_target_predictor_unit, attached by bind.
// Depends on btp_pkg.
module btp_checker import btp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              predict_taken,
	input logic [ADDR_W-1:0] predicted_pc,
	input logic [HIT_W-1:0]  hit_index,
	input logic [ADDR_W-1:0] branch_total,
	input logic [ADDR_W-1:0] mispredict_total
);

	logic              out_acc;
	logic [ADDR_W-1:0] last_br_q;
	logic [ADDR_W-1:0] last_mp_q;

	assign out_acc = out_valid && out_ready;

	// totals of the last result taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_br_q <= '0;
			last_mp_q <= '0;
		end else if (out_acc) begin
			last_br_q <= branch_total;
			last_mp_q <= mispredict_total;
		end
	end

	// a stalled result holds its predicted pc and both totals
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(predicted_pc)
			&& $stable(branch_total) && $stable(mispredict_total))
		else $error("result changed while stalled");

	// no index unless the stored target was chosen
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !predict_taken |-> hit_index == '0)
		else $error("hit_index set without a taken prediction");

	// each result moves the branch total by at most one
	a_br_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> branch_total == last_br_q || branch_total == last_br_q + ADDR_W'(1))
		else $error("branch total skipped");

	// each result moves the mispredict total by at most one
	a_mp_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> mispredict_total == last_mp_q
			|| mispredict_total == last_mp_q + ADDR_W'(1))
		else $error("mispredict total skipped");

	// one request never counts as both a branch and a mispredict
	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> !(branch_total != last_br_q && mispredict_total != last_mp_q))
		else $error("both totals moved on one result");

endmodule

bind branch_target_predictor_unit btp_checker u_btp_checker (.*);
